>>> hdl/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types, widths and a row entry helper for the cylinder support point block.
// ----------------------------------------------------------------------------
package csp_pkg;

	localparam int DIR_W      = 16;
	localparam int PT_W       = 24;
	localparam int ENT_W      = 16;
	localparam int ROW_W      = 48;
	localparam int OFS_W      = 20;
	localparam int OFFSET_W   = 60;
	localparam int SHAPE_W    = 32;
	localparam int LEN_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 60;

	localparam logic [ROW_W-1:0] ROW0_RST = 48'h0000_0000_4000;
	localparam logic [ROW_W-1:0] ROW1_RST = 48'h0000_4000_0000;
	localparam logic [ROW_W-1:0] ROW2_RST = 48'h4000_0000_0000;

	localparam logic signed [PT_W-1:0] SAT_MAX = 24'sh7FFFFF;
	localparam logic signed [PT_W-1:0] SAT_MIN = -24'sh800000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INV_ROW_0,
		REG_INV_ROW_1,
		REG_INV_ROW_2,
		REG_FWD_ROW_0,
		REG_FWD_ROW_1,
		REG_FWD_ROW_2,
		REG_OFFSET_XYZ,
		REG_CYL_SHAPE
	} cfg_reg_t;

	typedef logic [ROW_W-1:0] row_t;

	// one signed matrix entry, column 0 in the low bits
	function automatic logic signed [ENT_W-1:0] row_entry(input row_t row, input int col);
		return $signed(row[ENT_W*col +: ENT_W]);
	endfunction

endpackage

>>> hdl/csp_dir_if.sv
// ----------------------------------------------------------------------------
// csp_dir_if
// Search direction channel: valid/ready handshake with three signed components.
// ----------------------------------------------------------------------------
interface csp_dir_if;
	import csp_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [DIR_W-1:0] dir_x;
	logic signed [DIR_W-1:0] dir_y;
	logic signed [DIR_W-1:0] dir_z;

	modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
	modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

>>> hdl/csp_point_if.sv
// ----------------------------------------------------------------------------
// csp_point_if
// Support point channel: valid/ready handshake, saturated point and flags.
// ----------------------------------------------------------------------------
interface csp_point_if;
	import csp_pkg::*;

	logic                   valid;
	logic                   ready;
	logic signed [PT_W-1:0] point_x;
	logic signed [PT_W-1:0] point_y;
	logic signed [PT_W-1:0] point_z;
	logic                   zero_dir;
	logic                   axial_dir;

	modport source (output valid, output point_x, output point_y, output point_z,
		output zero_dir, output axial_dir, input ready);
	modport sink   (input valid, input point_x, input point_y, input point_z,
		input zero_dir, input axial_dir, output ready);
endinterface

>>> hdl/csp_isqrt.sv
// ----------------------------------------------------------------------------
// csp_isqrt
// Pipelined integer square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module csp_isqrt #(
	parameter int SB_W = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_i,
	input  logic [63:0]     n_i,
	input  logic [SB_W-1:0] sb_i,
	output logic            vld_o,
	output logic [31:0]     root_o,
	output logic [SB_W-1:0] sb_o
);
	localparam int STAGES = 32;

	logic [63:0]     rem_s [0:STAGES];
	logic [63:0]     res_s [0:STAGES];
	logic            vld_s [0:STAGES];
	logic [SB_W-1:0] sb_s  [0:STAGES];

	assign rem_s[0] = n_i;
	assign res_s[0] = '0;
	assign vld_s[0] = vld_i;
	assign sb_s[0]  = sb_i;

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
		logic [63:0] trial;

		assign trial = res_s[k] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[k+1] <= sb_s[k];
				if (rem_s[k] >= trial) begin
					rem_s[k+1] <= rem_s[k] - trial;
					res_s[k+1] <= (res_s[k] >> 1) + BIT;
				end else begin
					rem_s[k+1] <= rem_s[k];
					res_s[k+1] <= res_s[k] >> 1;
				end
			end
		end
	end

	assign vld_o  = vld_s[STAGES];
	assign root_o = res_s[STAGES][31:0];
	assign sb_o   = sb_s[STAGES];
endmodule

>>> hdl/csp_div.sv
// ----------------------------------------------------------------------------
// csp_div
// Pipelined restoring divider, two numerators over one shared divisor.
// ----------------------------------------------------------------------------
module csp_div #(
	parameter int NW   = 50,
	parameter int DW   = 33,
	parameter int QW   = 17,
	parameter int SB_W = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_i,
	input  logic [NW-1:0]   num_x_i,
	input  logic [NW-1:0]   num_y_i,
	input  logic [DW-1:0]   den_i,
	input  logic [SB_W-1:0] sb_i,
	output logic            vld_o,
	output logic [QW-1:0]   q_x_o,
	output logic [QW-1:0]   q_y_o,
	output logic [SB_W-1:0] sb_o
);
	logic [NW-1:0]   rx_s  [0:QW];
	logic [NW-1:0]   ry_s  [0:QW];
	logic [QW-1:0]   qx_s  [0:QW];
	logic [QW-1:0]   qy_s  [0:QW];
	logic [DW-1:0]   den_s [0:QW];
	logic            vld_s [0:QW];
	logic [SB_W-1:0] sb_s  [0:QW];

	assign rx_s[0]  = num_x_i;
	assign ry_s[0]  = num_y_i;
	assign qx_s[0]  = '0;
	assign qy_s[0]  = '0;
	assign den_s[0] = den_i;
	assign vld_s[0] = vld_i;
	assign sb_s[0]  = sb_i;

	// quotient is known to fit QW bits, so the top bit is tried first
	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [NW-1:0] trial;
		logic          gx, gy;

		assign trial = NW'(den_s[k]) << (QW - 1 - k);
		assign gx    = rx_s[k] >= trial;
		assign gy    = ry_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rx_s[k+1]  <= gx ? rx_s[k] - trial : rx_s[k];
				ry_s[k+1]  <= gy ? ry_s[k] - trial : ry_s[k];
				qx_s[k+1]  <= {qx_s[k][QW-2:0], gx};
				qy_s[k+1]  <= {qy_s[k][QW-2:0], gy};
				den_s[k+1] <= den_s[k];
				sb_s[k+1]  <= sb_s[k];
			end
		end
	end

	assign vld_o = vld_s[QW];
	assign q_x_o = qx_s[QW];
	assign q_y_o = qy_s[QW];
	assign sb_o  = sb_s[QW];
endmodule

>>> hdl/cylinder_support_point.sv
// ----------------------------------------------------------------------------
// cylinder_support_point
// Farthest point of a posed cylinder along a search direction.
// ----------------------------------------------------------------------------
// usage:
//   dir channel takes a signed search direction, point channel returns the
//   saturated support point with zero_dir and axial_dir flags, one beat out
//   for every beat in, in order.
//   config is a plain write port (cfg_we, cfg_idx, cfg_wdata); write it only
//   while no beats are in flight.
//   an accepted dir beat passes through five stages of rotate and square,
//   32 square root stages, one stage of set-up, 17 divider stages and
//   three stages of back-rotation and output on the way to its point beat.
//   throughput is one beat per cycle while the output is not stalled; the
//   pipeline is fully registered and each root or divider stage does one step.
//   reset clears all valid bits and loads identity rotations, zero offset
//   and zero shape.
//   when the receiver stalls with a beat waiting at the output the whole
//   pipeline holds; an empty output stage keeps the pipeline moving and dir ready.
// ----------------------------------------------------------------------------
module cylinder_support_point #(
	parameter int XY_EPS    = 1,
	parameter int FRAC_BITS = 14
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [csp_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [csp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	csp_dir_if.sink                         dir,
	csp_point_if.source                     point
);
	import csp_pkg::*;

	localparam int SQ_SB_W  = 2 * 47 + 5;
	localparam int DIV_SB_W = 5;

	// configuration
	row_t                inv_q [3];
	row_t                fwd_q [3];
	logic [OFFSET_W-1:0] offset_q;
	logic [SHAPE_W-1:0]  shape_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q[0] <= ROW0_RST;
			inv_q[1] <= ROW1_RST;
			inv_q[2] <= ROW2_RST;
			fwd_q[0] <= ROW0_RST;
			fwd_q[1] <= ROW1_RST;
			fwd_q[2] <= ROW2_RST;
			offset_q <= '0;
			shape_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_INV_ROW_0:  inv_q[0] <= cfg_wdata[ROW_W-1:0];
				REG_INV_ROW_1:  inv_q[1] <= cfg_wdata[ROW_W-1:0];
				REG_INV_ROW_2:  inv_q[2] <= cfg_wdata[ROW_W-1:0];
				REG_FWD_ROW_0:  fwd_q[0] <= cfg_wdata[ROW_W-1:0];
				REG_FWD_ROW_1:  fwd_q[1] <= cfg_wdata[ROW_W-1:0];
				REG_FWD_ROW_2:  fwd_q[2] <= cfg_wdata[ROW_W-1:0];
				REG_OFFSET_XYZ: offset_q <= cfg_wdata[OFFSET_W-1:0];
				REG_CYL_SHAPE:  shape_q  <= cfg_wdata[SHAPE_W-1:0];
				default: ;
			endcase
		end
	end

	logic [LEN_W-1:0] radius, half_h;
	assign radius = shape_q[LEN_W-1:0];
	assign half_h = shape_q[SHAPE_W-1:LEN_W];

	// pipeline control
	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic sq_vld, div_vld;

	assign en        = !vld_s9 || point.ready;
	assign dir.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s1 <= dir.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= sq_vld;
			vld_s7 <= div_vld;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	// s1: inverse rotation products
	logic signed [DIR_W-1:0] d_in [3];
	logic signed [31:0]      p_s1 [3][3];

	assign d_in[0] = dir.dir_x;
	assign d_in[1] = dir.dir_y;
	assign d_in[2] = dir.dir_z;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					p_s1[i][j] <= 32'(row_entry(inv_q[i], j) * d_in[j]);
				end
			end
		end
	end

	// s2: rotated direction, exact
	logic signed [33:0] t_s2 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				t_s2[i] <= 34'(p_s1[i][0]) + 34'(p_s1[i][1]) + 34'(p_s1[i][2]);
			end
		end
	end

	// s3: magnitudes, halved when either is too large for the square
	logic [33:0] ax_c, ay_c;
	logic        shr_c;
	logic [30:0] hx_s3, hy_s3;
	logic        shr_s3, negx_s3, negy_s3, zpos_s3, zero_s3;

	assign ax_c  = t_s2[0][33] ? 34'(-t_s2[0]) : 34'(t_s2[0]);
	assign ay_c  = t_s2[1][33] ? 34'(-t_s2[1]) : 34'(t_s2[1]);
	assign shr_c = (ax_c[33:31] != '0) || (ay_c[33:31] != '0);

	always_ff @(posedge clk) begin
		if (en) begin
			hx_s3   <= shr_c ? ax_c[31:1] : ax_c[30:0];
			hy_s3   <= shr_c ? ay_c[31:1] : ay_c[30:0];
			shr_s3  <= shr_c;
			negx_s3 <= t_s2[0][33];
			negy_s3 <= t_s2[1][33];
			zpos_s3 <= !t_s2[2][33] && (t_s2[2] != '0);
			zero_s3 <= (t_s2[0] == '0) && (t_s2[1] == '0) && (t_s2[2] == '0);
		end
	end

	// s4: squares and radius products
	logic [61:0] sqx_s4, sqy_s4;
	logic [46:0] hxr_s4, hyr_s4;
	logic        shr_s4, negx_s4, negy_s4, zpos_s4, zero_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s4  <= 62'(hx_s3) * 62'(hx_s3);
			sqy_s4  <= 62'(hy_s3) * 62'(hy_s3);
			hxr_s4  <= 47'(hx_s3) * 47'(radius);
			hyr_s4  <= 47'(hy_s3) * 47'(radius);
			shr_s4  <= shr_s3;
			negx_s4 <= negx_s3;
			negy_s4 <= negy_s3;
			zpos_s4 <= zpos_s3;
			zero_s4 <= zero_s3;
		end
	end

	// s5: squared length
	logic [63:0]        n_s5;
	logic [SQ_SB_W-1:0] sb_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s5  <= 64'(sqx_s4) + 64'(sqy_s4);
			sb_s5 <= {hxr_s4, hyr_s4, shr_s4, negx_s4, negy_s4, zpos_s4, zero_s4};
		end
	end

	logic [31:0]        root;
	logic [SQ_SB_W-1:0] sq_sb;

	csp_isqrt #(.SB_W(SQ_SB_W)) u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s5),
		.n_i    (n_s5),
		.sb_i   (sb_s5),
		.vld_o  (sq_vld),
		.root_o (root),
		.sb_o   (sq_sb)
	);

	// s6: rounding numerators and divisor
	logic [46:0] hxr_c, hyr_c;
	logic        shr_c6, negx_c, negy_c, zpos_c, zero_c, axial_c;

	assign {hxr_c, hyr_c, shr_c6, negx_c, negy_c, zpos_c, zero_c} = sq_sb;
	assign axial_c = ((33'(root) << shr_c6) < 33'(XY_EPS)) || (root == '0);

	logic [49:0]         numx_s6, numy_s6;
	logic [32:0]         den_s6;
	logic [DIV_SB_W-1:0] sb_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s6 <= 50'({hxr_c, 1'b0}) + 50'(root);
			numy_s6 <= 50'({hyr_c, 1'b0}) + 50'(root);
			den_s6  <= {root, 1'b0};
			sb_s6   <= {axial_c, negx_c, negy_c, zpos_c, zero_c};
		end
	end

	logic [16:0]         qx, qy;
	logic [DIV_SB_W-1:0] div_sb;

	csp_div #(.NW(50), .DW(33), .QW(17), .SB_W(DIV_SB_W)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_i   (vld_s6),
		.num_x_i (numx_s6),
		.num_y_i (numy_s6),
		.den_i   (den_s6),
		.sb_i    (sb_s6),
		.vld_o   (div_vld),
		.q_x_o   (qx),
		.q_y_o   (qy),
		.sb_o    (div_sb)
	);

	// s7: local point; quotient never exceeds the radius
	logic               ax7, nx7, ny7, zp7, zr7;
	logic signed [16:0] lx_c, ly_c;
	logic signed [16:0] loc_s7 [3];
	logic               axial_s7, zero_s7;

	assign {ax7, nx7, ny7, zp7, zr7} = div_sb;
	assign lx_c = nx7 ? -$signed({1'b0, qx[15:0]}) : $signed({1'b0, qx[15:0]});
	assign ly_c = ny7 ? -$signed({1'b0, qy[15:0]}) : $signed({1'b0, qy[15:0]});

	always_ff @(posedge clk) begin
		if (en) begin
			loc_s7[0] <= ax7 ? $signed({1'b0, radius}) : lx_c;
			loc_s7[1] <= ax7 ? 17'sd0 : ly_c;
			loc_s7[2] <= zp7 ? $signed({1'b0, half_h}) : -$signed({1'b0, half_h});
			axial_s7  <= ax7;
			zero_s7   <= zr7;
		end
	end

	// s8: forward rotation products
	logic signed [32:0] fp_s8 [3][3];
	logic               axial_s8, zero_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					fp_s8[i][j] <= 33'(row_entry(fwd_q[i], j) * loc_s7[j]);
				end
			end
			axial_s8 <= axial_s7;
			zero_s8  <= zero_s7;
		end
	end

	// s9: sum, round to integer, translate, saturate
	logic signed [34:0] acc_c [3];
	logic signed [35:0] pos_c [3];
	logic signed [PT_W-1:0] sat_c [3];
	logic signed [PT_W-1:0] pt_s9 [3];
	logic               axial_s9, zero_s9;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc_c[i] = 35'(fp_s8[i][0]) + 35'(fp_s8[i][1]) + 35'(fp_s8[i][2])
				+ (35'sd1 <<< (FRAC_BITS - 1));
			pos_c[i] = 36'(acc_c[i] >>> FRAC_BITS)
				+ 36'($signed(offset_q[OFS_W*i +: OFS_W]));
			if (pos_c[i] > 36'(SAT_MAX)) begin
				sat_c[i] = SAT_MAX;
			end else if (pos_c[i] < 36'(SAT_MIN)) begin
				sat_c[i] = SAT_MIN;
			end else begin
				sat_c[i] = pos_c[i][PT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pt_s9[i] <= zero_s8 ? '0 : sat_c[i];
			end
			axial_s9 <= axial_s8 && !zero_s8;
			zero_s9  <= zero_s8;
		end
	end

	assign point.valid     = vld_s9;
	assign point.point_x   = pt_s9[0];
	assign point.point_y   = pt_s9[1];
	assign point.point_z   = pt_s9[2];
	assign point.zero_dir  = zero_s9;
	assign point.axial_dir = axial_s9;

	// checks
	a_zero_origin: assert property (@(posedge clk) disable iff (!arst_n)
		point.valid && point.zero_dir |->
			point.point_x == '0 && point.point_y == '0 && point.point_z == '0)
		else $error("zero direction beat carries a non-zero point");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		point.valid |-> !(point.zero_dir && point.axial_dir))
		else $error("zero_dir and axial_dir both set");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s9 && !point.ready |=> !dir.ready || vld_s9)
		else $error("output beat dropped while receiver stalled");
endmodule

>>> sim/csp_support_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_support_checker
// Watches the direction and point channels and the register write port,
// predicts each support point from a local copy of the registers and compares
// every point beat, field by field, against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module csp_support_checker
	import csp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	csp_dir_if                    dir,
	csp_point_if                  point,
	input  logic                  drain,
	output int                    fail_count,
	output int                    pending
);

	typedef struct packed {
		logic signed [PT_W-1:0] x;
		logic signed [PT_W-1:0] y;
		logic signed [PT_W-1:0] z;
		logic                   zero_dir;
		logic                   axial_dir;
	} support_t;

	localparam int FRAC = 14;
	localparam longint EPS = 1;

	row_t                  inv_rows [3];
	row_t                  fwd_rows [3];
	logic [OFFSET_W-1:0]   offset_reg;
	logic [SHAPE_W-1:0]    shape_reg;
	logic                  drain_q;
	support_t              expected_points [$];

	assign pending = expected_points.size();

	function automatic longint isqrt(input longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint ent(input row_t row, input int col);
		return longint'($signed(row[16*col +: 16]));
	endfunction

	function automatic logic signed [PT_W-1:0] clamp24(input longint v);
		if (v > 64'sd8388607) v = 8388607;
		if (v < -64'sd8388608) v = -8388608;
		return v[PT_W-1:0];
	endfunction

	function automatic support_t support_of(input longint dx, input longint dy, input longint dz);
		longint d [3], t [3], loc [3], acc, w;
		longint unsigned ax, ay, hx, hy, ls, r, q;
		longint h;
		int s;
		support_t p;
		d[0] = dx; d[1] = dy; d[2] = dz;
		r = 64'(shape_reg[15:0]);
		h = longint'(shape_reg[31:16]);
		for (int i = 0; i < 3; i++)
			t[i] = ent(inv_rows[i], 0) * d[0] + ent(inv_rows[i], 1) * d[1]
				+ ent(inv_rows[i], 2) * d[2];
		p = '0;
		if (t[0] == 0 && t[1] == 0 && t[2] == 0) begin
			p.zero_dir = 1'b1;
			return p;
		end
		ax = t[0] < 0 ? -t[0] : t[0];
		ay = t[1] < 0 ? -t[1] : t[1];
		s = (ax >= 64'd2147483648 || ay >= 64'd2147483648) ? 1 : 0;
		hx = ax >> s;
		hy = ay >> s;
		ls = isqrt(hx * hx + hy * hy);
		if ((ls << s) < EPS || ls == 0) begin
			p.axial_dir = 1'b1;
			loc[0] = r;
			loc[1] = 0;
		end else begin
			q = (hx * r * 2 + ls) / (ls * 2);
			loc[0] = t[0] < 0 ? -longint'(q) : longint'(q);
			q = (hy * r * 2 + ls) / (ls * 2);
			loc[1] = t[1] < 0 ? -longint'(q) : longint'(q);
		end
		loc[2] = t[2] > 0 ? h : -h;
		for (int i = 0; i < 3; i++) begin
			acc = ent(fwd_rows[i], 0) * loc[0] + ent(fwd_rows[i], 1) * loc[1]
				+ ent(fwd_rows[i], 2) * loc[2];
			w = acc + (64'sd1 <<< (FRAC - 1));
			// floor division by the fraction scale
			acc = w >>> FRAC;
			acc += longint'($signed(offset_reg[20*i +: 20]));
			if (i == 0) p.x = clamp24(acc);
			else if (i == 1) p.y = clamp24(acc);
			else p.z = clamp24(acc);
		end
		return p;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		support_t exp_p;
		int       errs;
		if (!arst_n) begin
			inv_rows[0] <= ROW0_RST; inv_rows[1] <= ROW1_RST; inv_rows[2] <= ROW2_RST;
			fwd_rows[0] <= ROW0_RST; fwd_rows[1] <= ROW1_RST; fwd_rows[2] <= ROW2_RST;
			offset_reg <= '0;
			shape_reg <= '0;
			drain_q <= 1'b0;
			fail_count <= 0;
			expected_points.delete();
		end else begin
			errs = 0;
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_idx))
					REG_INV_ROW_0:  inv_rows[0] <= cfg_wdata[ROW_W-1:0];
					REG_INV_ROW_1:  inv_rows[1] <= cfg_wdata[ROW_W-1:0];
					REG_INV_ROW_2:  inv_rows[2] <= cfg_wdata[ROW_W-1:0];
					REG_FWD_ROW_0:  fwd_rows[0] <= cfg_wdata[ROW_W-1:0];
					REG_FWD_ROW_1:  fwd_rows[1] <= cfg_wdata[ROW_W-1:0];
					REG_FWD_ROW_2:  fwd_rows[2] <= cfg_wdata[ROW_W-1:0];
					REG_OFFSET_XYZ: offset_reg <= cfg_wdata[OFFSET_W-1:0];
					REG_CYL_SHAPE:  shape_reg <= cfg_wdata[SHAPE_W-1:0];
					default: ;
				endcase
			end
			if (dir.valid && dir.ready)
				expected_points.push_back(support_of(longint'(dir.dir_x),
					longint'(dir.dir_y), longint'(dir.dir_z)));
			if (point.valid && point.ready) begin
				if (expected_points.size() == 0) begin
					$display("%0t: point beat with nothing expected, actual %h", $time,
						{point.point_x, point.point_y, point.point_z,
						point.zero_dir, point.axial_dir});
					errs++;
				end else begin
					exp_p = expected_points.pop_front();
					if (exp_p.x !== point.point_x || exp_p.y !== point.point_y
						|| exp_p.z !== point.point_z || exp_p.zero_dir !== point.zero_dir
						|| exp_p.axial_dir !== point.axial_dir) begin
						$display("%0t: point mismatch expected (%0d %0d %0d z%0b a%0b) actual (%0d %0d %0d z%0b a%0b)",
							$time, exp_p.x, exp_p.y, exp_p.z, exp_p.zero_dir, exp_p.axial_dir,
							point.point_x, point.point_y, point.point_z, point.zero_dir,
							point.axial_dir);
						errs++;
					end
				end
			end
			// left-over expectations count as failures once the run is wound down
			if (drain && !drain_q && expected_points.size() != 0) begin
				$display("%0t: %0d point beats never arrived, expected %h actual none", $time,
					expected_points.size(), expected_points[0]);
				errs++;
			end
			drain_q <= drain;
			fail_count <= fail_count + errs;
		end
	end

endmodule

>>> sim/cylinder_support_point_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cylinder_support_point_tb
// Drives search directions and register settings into the support point
// block with random stalls on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module cylinder_support_point_tb;
	import csp_pkg::*;

	localparam int LIMIT = 400000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  drain;
	logic                  no_idle;
	int                    fail_count;
	int                    pending;
	int                    cycles;

	csp_dir_if   dir ();
	csp_point_if point ();

	cylinder_support_point u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .dir(dir.sink), .point(point.source)
	);

	csp_support_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .dir(dir), .point(point), .drain(drain),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("cylinder_support_point regression: fail");
				$finish;
			end
		end
	end

	// receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point.ready <= 1'b0;
		end else begin
			point.ready <= no_idle || ($urandom_range(99) >= 26);
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// valid stays high after an accept so that beats can follow back to back
	task automatic send_dir(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
		while (!no_idle && $urandom_range(99) < 26) begin
			dir.valid <= 1'b0;
			@(posedge clk);
		end
		dir.valid <= 1'b1;
		dir.dir_x <= x;
		dir.dir_y <= y;
		dir.dir_z <= z;
		do @(posedge clk); while (!dir.ready);
	endtask

	task automatic settle;
		dir.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (70) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_dir();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'($signed($urandom_range(8)) - 4);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_entry();
		case ($urandom_range(4))
			0: return 16'h4000;
			1: return 16'hC000;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_pose(input int kind);
		logic [ROW_W-1:0] row;
		for (int r = 0; r < 6; r++) begin
			row = {rand_entry(), rand_entry(), rand_entry()};
			if (kind == 0) row = (r % 3 == 0) ? ROW0_RST : (r % 3 == 1) ? ROW1_RST : ROW2_RST;
			if (kind == 1) row = {ROW_W{1'b1}};
			if (kind == 2) row = {3{16'h8000}};
			write_reg(cfg_reg_t'(r), CFG_DATA_W'(row));
		end
		case (kind)
			1: write_reg(REG_OFFSET_XYZ, {OFFSET_W{1'b1}});
			2: write_reg(REG_OFFSET_XYZ, {20'h80000, 20'h7FFFF, 20'h80000});
			default: write_reg(REG_OFFSET_XYZ, CFG_DATA_W'({$urandom, $urandom}));
		endcase
		case (kind)
			1: write_reg(REG_CYL_SHAPE, CFG_DATA_W'(32'hFFFF_FFFF));
			2: write_reg(REG_CYL_SHAPE, CFG_DATA_W'(32'h0000_0000));
			default: write_reg(REG_CYL_SHAPE,
				CFG_DATA_W'({16'($urandom_range(4000)), 16'($urandom)}));
		endcase
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		dir.valid = 1'b0;
		dir.dir_x = '0;
		dir.dir_y = '0;
		dir.dir_z = '0;
		drain = 1'b0;
		no_idle = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: identity pose with a shape, then field extremes
		write_reg(REG_CYL_SHAPE, CFG_DATA_W'({16'd300, 16'd1000}));
		write_reg(REG_OFFSET_XYZ, {20'd5, 20'hFFFFF, 20'd100});
		send_dir(16'h0000, 16'h0000, 16'h0000);
		send_dir(16'h0000, 16'h0000, 16'h0005);
		send_dir(16'h0000, 16'h0000, 16'hFFFB);
		send_dir(16'h0001, 16'h0000, 16'h0000);
		send_dir(16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_dir(16'h8000, 16'h8000, 16'h8000);
		send_dir(16'h8000, 16'h7FFF, 16'h0001);
		send_dir(16'hFFFF, 16'h0001, 16'hFFFF);
		send_dir(16'h0003, 16'hFFFC, 16'h0000);
		settle();
		// every register all ones: rotation entries of -1
		random_pose(1);
		send_dir(16'h8000, 16'h8000, 16'h8000);
		send_dir(16'h7FFF, 16'h0000, 16'h8000);
		send_dir(16'h1234, 16'hABCD, 16'h0000);
		settle();
		random_pose(2);
		send_dir(16'h8000, 16'h8000, 16'h8000);
		send_dir(16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_dir(16'h0000, 16'h0000, 16'h0000);
		settle();

		for (int phase = 0; phase < 8; phase++) begin
			random_pose(phase == 7 ? 0 : 3);
			no_idle = (phase == 4);
			for (int n = 0; n < 60; n++)
				send_dir(rand_dir(), rand_dir(), rand_dir());
			settle();
		end
		no_idle = 1'b0;

		drain = 1'b1;
		@(posedge clk);
		@(posedge clk);
		if (fail_count == 0) begin
			$display("cylinder_support_point regression: pass");
		end else begin
			$display("cylinder_support_point regression: fail");
		end
		$finish;
	end

endmodule

>>> files.f
hdl/csp_pkg.sv
hdl/csp_dir_if.sv
hdl/csp_point_if.sv
hdl/csp_isqrt.sv
hdl/csp_div.sv
hdl/cylinder_support_point.sv
sim/csp_support_checker.sv
sim/cylinder_support_point_tb.sv
